// ----- hdl/accel_sample_health_monitor_assert.svh -----
// Assertion macros shared by the health monitor RTL.
// ASHM_ASSERT checks an expression at every rising clock edge out of reset.
// ASHM_ASSERT_IMPL checks that a condition implies a consequence.
`ifndef ACCEL_SAMPLE_HEALTH_MONITOR_ASSERT_SVH
`define ACCEL_SAMPLE_HEALTH_MONITOR_ASSERT_SVH
`ifndef SYNTHESIS
`define ASHM_ASSERT(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASHM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASHM_ASSERT(lbl, clk, rst_n, expr, msg)
`define ASHM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/ashm_pkg.sv -----
package ashm_pkg;

  localparam int SAMPLE_W_DEFAULT = 16;
  localparam int COUNT_W_DEFAULT  = 16;
  localparam int QUEUE_DEPTH      = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int SUM_LIMIT_W    = 17;
  localparam int AXIS_LIMIT_W   = 15;
  localparam int WINDOW_W       = 16;
  localparam int PERCENT_W      = 7;
  localparam int BAD_MIN_W      = 16;
  localparam int SAME_LIMIT_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SUM_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERCENT_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_MIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAME_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MON_ENABLE   = 3'd6;

  // input kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // report kinds
  localparam logic [1:0] KIND_DATA_EXC = 2'd0;
  localparam logic [1:0] KIND_ALL_ZERO = 2'd1;
  localparam logic [1:0] KIND_STUCK    = 2'd2;

  localparam int PCT_SCALE        = 100;
  localparam int ZERO_RUN_LIMIT   = 10;
  localparam int STUCK_REPORT_CAP = 10;
  localparam int RUN_W            = 8;
  localparam int ZERO_RUN_W       = 4;
  localparam int STUCK_CNT_W      = 4;

  typedef struct packed {
    logic [SUM_LIMIT_W-1:0]  sum_limit;
    logic [AXIS_LIMIT_W-1:0] axis_limit;
    logic [WINDOW_W-1:0]     window_ticks;
    logic [PERCENT_W-1:0]    percent_min;
    logic [BAD_MIN_W-1:0]    bad_min;
    logic [SAME_LIMIT_W-1:0] same_limit;
    logic                    monitor_enabled;
  } cfg_t;

endpackage

// ----- hdl/ashm_front.sv -----
module ashm_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  ashm_pkg::cfg_t                            cfg_i,
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // x, y, z from bit 0 up
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata_i,
  // cmd
  input  logic                                      s_axis_tuser_i,
  input  logic                                      q_full_i,
  output logic                                      q_push_o,
  // {cmd, bad, zero, z, y, x}
  output logic [3*SAMPLE_WIDTH+2:0]                 q_data_o
);
  import ashm_pkg::*;

  localparam int SumW    = SAMPLE_WIDTH + 2;
  localparam int SumCmpW = (SumW > SUM_LIMIT_W) ? SumW : SUM_LIMIT_W;
  localparam int AxCmpW  = (SAMPLE_WIDTH > AXIS_LIMIT_W) ? SAMPLE_WIDTH : AXIS_LIMIT_W;

  function automatic logic [SAMPLE_WIDTH-1:0] magnitude(input logic [SAMPLE_WIDTH-1:0] v);
    return v[SAMPLE_WIDTH-1] ? (~v + SAMPLE_WIDTH'(1)) : v;
  endfunction

  logic [SAMPLE_WIDTH-1:0] in_x, in_y, in_z;
  logic [SAMPLE_WIDTH-1:0] mag_x, mag_y, mag_z;
  logic [SumW-1:0]         sum, sum_mag;
  logic                    bad, all_zero;

  logic                    st_valid_q;
  logic [3*SAMPLE_WIDTH+2:0] st_data_q;

  assign in_x = s_axis_tdata_i[SAMPLE_WIDTH-1:0];
  assign in_y = s_axis_tdata_i[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign in_z = s_axis_tdata_i[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];

  always_comb begin
    sum = {{2{in_x[SAMPLE_WIDTH-1]}}, in_x} + {{2{in_y[SAMPLE_WIDTH-1]}}, in_y}
        + {{2{in_z[SAMPLE_WIDTH-1]}}, in_z};
    sum_mag = sum[SumW-1] ? (~sum + SumW'(1)) : sum;
    mag_x = magnitude(in_x);
    mag_y = magnitude(in_y);
    mag_z = magnitude(in_z);
    bad = (SumCmpW'(sum_mag) > SumCmpW'(cfg_i.sum_limit))
       || (AxCmpW'(mag_x) > AxCmpW'(cfg_i.axis_limit))
       || (AxCmpW'(mag_y) > AxCmpW'(cfg_i.axis_limit))
       || (AxCmpW'(mag_z) > AxCmpW'(cfg_i.axis_limit));
    all_zero = ~|{in_x, in_y, in_z};
  end

  assign q_push_o        = st_valid_q && !q_full_i;
  assign s_axis_tready_o = !st_valid_q || !q_full_i;
  assign q_data_o        = st_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      st_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      st_data_q <= {s_axis_tuser_i, bad, all_zero, in_z, in_y, in_x};
    end
  end

endmodule

// ----- hdl/ashm_fifo.sv -----
`include "accel_sample_health_monitor_assert.svh"

module ashm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ASHM_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push_i, !full_o || pop_i, "queue overflow")
  `ASHM_ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o, "queue underflow")
  `ASHM_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CntW'(DEPTH), "queue count out of range")

endmodule

// ----- hdl/ashm_back.sv -----
`include "accel_sample_health_monitor_assert.svh"

module ashm_back #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ashm_pkg::cfg_t                      cfg_i,
  input  logic                                q_empty_i,
  // {cmd, bad, zero, z, y, x}
  input  logic [3*SAMPLE_WIDTH+2:0]           q_data_i,
  output logic                                q_pop_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // report_x, report_y, report_z from bit 0 up
  output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // report_kind
  output logic [1:0]                          m_axis_tuser_o,
  // last_report
  output logic                                m_axis_tlast_o
);
  import ashm_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int CW     = COUNT_WIDTH;
  localparam int DataW  = ((3*SAMPLE_WIDTH+7)/8)*8;
  localparam int ProdW  = COUNT_WIDTH + PERCENT_W;
  localparam int WinCmpW = (CW > WINDOW_W) ? CW : WINDOW_W;
  localparam int BadCmpW = (CW > BAD_MIN_W) ? CW : BAD_MIN_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (&v) ? v : v + CW'(1);
  endfunction

  logic [2:0] state_q, state_d;

  // item under work
  logic          it_cmd_q, it_bad_q, it_zero_q;
  logic [SW-1:0] it_xyz_q [3];

  // monitor state
  logic                   armed_q, armed_d;
  logic                   counting_q, counting_d;
  logic [CW-1:0]          bad_cnt_q, bad_cnt_d;
  logic [CW-1:0]          tot_cnt_q, tot_cnt_d;
  logic [CW-1:0]          elapsed_q, elapsed_d;
  logic [SW-1:0]          cap_q [3];
  logic [SW-1:0]          cap_d [3];
  logic [ZERO_RUN_W-1:0]  zero_run_q, zero_run_d;
  logic [RUN_W-1:0]       run_q [3];
  logic [RUN_W-1:0]       run_d [3];
  logic [SW-1:0]          prev_q [3];
  logic [SW-1:0]          prev_d [3];
  logic [STUCK_CNT_W-1:0] stuck_cnt_q, stuck_cnt_d;

  // window-end compare
  logic [ProdW-1:0] prod_bad_q, prod_bad_d;
  logic [ProdW-1:0] prod_tot_q, prod_tot_d;

  // pending reports of the current item
  logic          pend_exc_q, pend_exc_d;
  logic          pend_zero_q, pend_zero_d;
  logic          pend_stuck_q, pend_stuck_d;
  logic [SW-1:0] shown_q [3];
  logic [SW-1:0] shown_d [3];

  // output register
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_kind_q, out_kind_d;
  logic          out_last_q, out_last_d;
  logic [SW-1:0] out_xyz_q [3];
  logic          out_load;

  // scratch
  logic          first_bad;
  logic          flagged;
  logic [CW-1:0] tot_base, bad_base, el_inc;
  logic [RUN_W-1:0] run_tmp;

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    state_d      = state_q;
    armed_d      = armed_q;
    counting_d   = counting_q;
    bad_cnt_d    = bad_cnt_q;
    tot_cnt_d    = tot_cnt_q;
    elapsed_d    = elapsed_q;
    cap_d        = cap_q;
    zero_run_d   = zero_run_q;
    run_d        = run_q;
    prev_d       = prev_q;
    stuck_cnt_d  = stuck_cnt_q;
    prod_bad_d   = prod_bad_q;
    prod_tot_d   = prod_tot_q;
    pend_exc_d   = pend_exc_q;
    pend_zero_d  = pend_zero_q;
    pend_stuck_d = pend_stuck_q;
    shown_d      = shown_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_kind_d   = out_kind_q;
    out_last_d   = out_last_q;
    out_load     = 1'b0;
    first_bad    = 1'b0;
    flagged      = 1'b0;
    tot_base     = tot_cnt_q;
    bad_base     = bad_cnt_q;
    el_inc       = sat_inc(elapsed_q);
    run_tmp      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (it_cmd_q == CMD_TICK) begin
          state_d = ST_IDLE;
          if (counting_q) begin
            elapsed_d = el_inc;
            if (WinCmpW'(el_inc) >= WinCmpW'(cfg_i.window_ticks)) begin
              state_d = ST_MUL;
            end
          end
        end else begin
          // range test and window counting
          first_bad  = armed_q && it_bad_q;
          armed_d    = armed_q && !it_bad_q;
          counting_d = counting_q || first_bad;
          if (first_bad) begin
            tot_base  = CW'(1);
            bad_base  = CW'(1);
            elapsed_d = '0;
            cap_d     = it_xyz_q;
          end
          if (counting_d) begin
            tot_cnt_d = sat_inc(tot_base);
            bad_cnt_d = it_bad_q ? sat_inc(bad_base) : bad_base;
          end
          if (armed_d || first_bad) begin
            shown_d = it_xyz_q;
          end else begin
            shown_d = cap_q;
          end

          // all-zero run
          pend_zero_d = 1'b0;
          if (it_zero_q) begin
            if (zero_run_q > ZERO_RUN_W'(ZERO_RUN_LIMIT)) begin
              zero_run_d  = '0;
              pend_zero_d = 1'b1;
            end else begin
              zero_run_d = zero_run_q + ZERO_RUN_W'(1);
            end
          end else begin
            zero_run_d = '0;
          end

          // stuck axes
          for (int i = 0; i < 3; i++) begin
            if (prev_q[i] == it_xyz_q[i]) begin
              run_tmp = (&run_q[i]) ? run_q[i] : run_q[i] + RUN_W'(1);
            end else begin
              run_tmp = '0;
            end
            if (run_tmp >= cfg_i.same_limit) begin
              run_tmp = '0;
              flagged = 1'b1;
            end
            run_d[i]  = run_tmp;
            prev_d[i] = it_xyz_q[i];
          end
          pend_stuck_d = flagged && (stuck_cnt_q < STUCK_CNT_W'(STUCK_REPORT_CAP));
          if (pend_stuck_d) begin
            stuck_cnt_d = stuck_cnt_q + STUCK_CNT_W'(1);
          end
          pend_exc_d = 1'b0;
          state_d    = (pend_zero_d || pend_stuck_d) ? ST_EMIT : ST_IDLE;
        end
      end

      ST_MUL: begin
        // 100*bad/total >= pct  <=>  100*bad >= pct*total, total is never zero here
        prod_bad_d = ProdW'(bad_cnt_q) * ProdW'(PCT_SCALE);
        prod_tot_d = ProdW'(cfg_i.percent_min) * ProdW'(tot_cnt_q);
        state_d    = ST_CMP;
      end

      ST_CMP: begin
        pend_exc_d   = (prod_bad_q >= prod_tot_q)
                    && (BadCmpW'(bad_cnt_q) >= BadCmpW'(cfg_i.bad_min))
                    && cfg_i.monitor_enabled;
        pend_zero_d  = 1'b0;
        pend_stuck_d = 1'b0;
        shown_d      = cap_q;
        armed_d      = 1'b1;
        counting_d   = 1'b0;
        bad_cnt_d    = '0;
        tot_cnt_d    = '0;
        elapsed_d    = '0;
        state_d      = pend_exc_d ? ST_EMIT : ST_IDLE;
      end

      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (pend_exc_q) begin
            out_kind_d = KIND_DATA_EXC;
            pend_exc_d = 1'b0;
          end else if (pend_zero_q) begin
            out_kind_d  = KIND_ALL_ZERO;
            pend_zero_d = 1'b0;
          end else begin
            out_kind_d   = KIND_STUCK;
            pend_stuck_d = 1'b0;
          end
          out_last_d = !(pend_exc_d || pend_zero_d || pend_stuck_d);
          if (out_last_d) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      armed_q      <= 1'b1;
      counting_q   <= 1'b0;
      bad_cnt_q    <= '0;
      tot_cnt_q    <= '0;
      elapsed_q    <= '0;
      zero_run_q   <= '0;
      stuck_cnt_q  <= '0;
      pend_exc_q   <= 1'b0;
      pend_zero_q  <= 1'b0;
      pend_stuck_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        run_q[i]  <= '0;
        prev_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      armed_q      <= armed_d;
      counting_q   <= counting_d;
      bad_cnt_q    <= bad_cnt_d;
      tot_cnt_q    <= tot_cnt_d;
      elapsed_q    <= elapsed_d;
      zero_run_q   <= zero_run_d;
      stuck_cnt_q  <= stuck_cnt_d;
      pend_exc_q   <= pend_exc_d;
      pend_zero_q  <= pend_zero_d;
      pend_stuck_q <= pend_stuck_d;
      out_valid_q  <= out_valid_d;
      run_q        <= run_d;
      prev_q       <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      it_cmd_q  <= q_data_i[3*SW+2];
      it_bad_q  <= q_data_i[3*SW+1];
      it_zero_q <= q_data_i[3*SW];
      for (int i = 0; i < 3; i++) begin
        it_xyz_q[i] <= q_data_i[i*SW +: SW];
      end
    end
    cap_q      <= cap_d;
    shown_q    <= shown_d;
    prod_bad_q <= prod_bad_d;
    prod_tot_q <= prod_tot_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_last_q <= out_last_d;
      out_xyz_q  <= shown_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = DataW'({out_xyz_q[2], out_xyz_q[1], out_xyz_q[0]});

  `ASHM_ASSERT(a_arm_or_count, clk_i, rst_ni, !(armed_q && counting_q),
    "armed while a window is open")
  `ASHM_ASSERT(a_stuck_cap, clk_i, rst_ni,
    stuck_cnt_q <= STUCK_CNT_W'(STUCK_REPORT_CAP), "stuck report cap exceeded")
  `ASHM_ASSERT_IMPL(a_bad_le_total, clk_i, rst_ni, counting_q, bad_cnt_q <= tot_cnt_q,
    "bad count above total count")

endmodule

// ----- hdl/accel_sample_health_monitor.sv -----
// Accelerometer sample health monitor.
// Input stream s_axis: tuser is the item kind (0 sample, 1 time tick), tdata carries
// x, y, z as two's complement values, x in the lowest bits. Output stream m_axis:
// tuser is the report kind (0 data exception, 1 all axes zero, 2 axis stuck), tdata
// the reported x, y, z, tlast marks the last report caused by one input item.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i;
// write only while no item is in flight.
// Sequencing: the back-end sequencer takes a sample through the states IDLE and
// EXEC, then EMIT once per report; a tick goes through IDLE and EXEC, and when it
// closes a window also through MUL (the two percentage products) and CMP (the
// compare), then EMIT for a report. The sequencer takes a new item only in IDLE
// and sets the rate; the front stage and a 2-entry queue keep taking items meanwhile.
// Reset clears the queue and output register, arms the monitor and loads the register
// defaults. If the receiver stalls, the report holds in the output register, the
// sequencer waits, and input backs up through the queue into s_axis_tready_o.
module accel_sample_health_monitor #(
  parameter int SAMPLE_WIDTH = ashm_pkg::SAMPLE_W_DEFAULT,
  parameter int COUNT_WIDTH  = ashm_pkg::COUNT_W_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ashm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ashm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // sample_x, sample_y, sample_z from bit 0 up
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]  s_axis_tdata_i,
  // cmd
  input  logic                                 s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // report_x, report_y, report_z from bit 0 up
  output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]  m_axis_tdata_o,
  // report_kind
  output logic [1:0]                           m_axis_tuser_o,
  // last_report
  output logic                                 m_axis_tlast_o
);
  import ashm_pkg::*;

  localparam int EntryW = 3*SAMPLE_WIDTH + 3;

  cfg_t cfg_q;

  logic              q_push, q_pop, q_full, q_empty;
  logic [EntryW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sum_limit       <= SUM_LIMIT_W'(6144);
      cfg_q.axis_limit      <= AXIS_LIMIT_W'(2048);
      cfg_q.window_ticks    <= WINDOW_W'(2000);
      cfg_q.percent_min     <= PERCENT_W'(50);
      cfg_q.bad_min         <= BAD_MIN_W'(10);
      cfg_q.same_limit      <= SAME_LIMIT_W'(20);
      cfg_q.monitor_enabled <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SUM_LIMIT:    cfg_q.sum_limit       <= cfg_wdata_i[SUM_LIMIT_W-1:0];
        CFG_AXIS_LIMIT:   cfg_q.axis_limit      <= cfg_wdata_i[AXIS_LIMIT_W-1:0];
        CFG_WINDOW_TICKS: cfg_q.window_ticks    <= cfg_wdata_i[WINDOW_W-1:0];
        CFG_PERCENT_MIN:  cfg_q.percent_min     <= cfg_wdata_i[PERCENT_W-1:0];
        CFG_BAD_MIN:      cfg_q.bad_min         <= cfg_wdata_i[BAD_MIN_W-1:0];
        CFG_SAME_LIMIT:   cfg_q.same_limit      <= cfg_wdata_i[SAME_LIMIT_W-1:0];
        CFG_MON_ENABLE:   cfg_q.monitor_enabled <= cfg_wdata_i[0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  ashm_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata)
  );

  ashm_fifo #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  ashm_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_empty_i       (q_empty),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ----- sim/ashm_report_checker.sv -----
module ashm_report_checker (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              cfg_we_i,
  input  logic [ashm_pkg::CFG_IDX_W-1:0]                    cfg_idx_i,
  input  logic [ashm_pkg::CFG_DATA_W-1:0]                   cfg_wdata_i,
  input  logic                                              s_axis_tvalid_i,
  input  logic                                              s_axis_tready_i,
  // sample_x, sample_y, sample_z from bit 0 up
  input  logic [((3*ashm_pkg::SAMPLE_W_DEFAULT+7)/8)*8-1:0] s_axis_tdata_i,
  // cmd
  input  logic                                              s_axis_tuser_i,
  input  logic                                              m_axis_tvalid_i,
  input  logic                                              m_axis_tready_i,
  // report_x, report_y, report_z from bit 0 up
  input  logic [((3*ashm_pkg::SAMPLE_W_DEFAULT+7)/8)*8-1:0] m_axis_tdata_i,
  // report_kind
  input  logic [1:0]                                        m_axis_tuser_i,
  input  logic                                              m_axis_tlast_i,
  output int unsigned                                       pending_o,
  output int unsigned                                       errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ashm_pkg::*;

  localparam int DATA_W = ((3*SAMPLE_W_DEFAULT+7)/8)*8;

  typedef logic signed [SAMPLE_W_DEFAULT-1:0] axis_t;
  typedef logic [COUNT_W_DEFAULT-1:0] count_t;

  typedef struct packed {
    logic [1:0] kind;
    axis_t      x;
    axis_t      y;
    axis_t      z;
    logic       last;
  } report_t;

  cfg_t                  cfg;
  logic                  armed;
  logic                  counting;
  count_t                bad_cnt;
  count_t                total_cnt;
  count_t                ticks_seen;
  axis_t                 bad_xyz [3];
  axis_t                 prev_xyz [3];
  logic [ZERO_RUN_W-1:0] zero_run;
  logic [RUN_W-1:0]      same_run [3];
  int unsigned           stuck_sent;
  int unsigned           err_count = 0;
  report_t               reports_due [$];

  function automatic count_t count_up(input count_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic reset_monitor();
    cfg.sum_limit       = 17'd6144;
    cfg.axis_limit      = 15'd2048;
    cfg.window_ticks    = 16'd2000;
    cfg.percent_min     = 7'd50;
    cfg.bad_min         = 16'd10;
    cfg.same_limit      = 8'd20;
    cfg.monitor_enabled = 1'b1;
    armed      = 1'b1;
    counting   = 1'b0;
    bad_cnt    = '0;
    total_cnt  = '0;
    ticks_seen = '0;
    zero_run   = '0;
    stuck_sent = 0;
    for (int i = 0; i < 3; i++) begin
      bad_xyz[i]  = '0;
      prev_xyz[i] = '0;
      same_run[i] = '0;
    end
    reports_due.delete();
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_SUM_LIMIT:    cfg.sum_limit       = value[SUM_LIMIT_W-1:0];
      CFG_AXIS_LIMIT:   cfg.axis_limit      = value[AXIS_LIMIT_W-1:0];
      CFG_WINDOW_TICKS: cfg.window_ticks    = value[WINDOW_W-1:0];
      CFG_PERCENT_MIN:  cfg.percent_min     = value[PERCENT_W-1:0];
      CFG_BAD_MIN:      cfg.bad_min         = value[BAD_MIN_W-1:0];
      CFG_SAME_LIMIT:   cfg.same_limit      = value[SAME_LIMIT_W-1:0];
      CFG_MON_ENABLE:   cfg.monitor_enabled = value[0];
      default: ;
    endcase
  endtask

  // Updates the health state for one transaction and queues the reports it raises.
  task automatic predict_reports(input logic cmd, input logic [DATA_W-1:0] data);
    axis_t       cur [3];
    axis_t       shown [3];
    report_t     made [2];
    int          sum_xyz;
    logic        bad;
    logic        flagged;
    int          n;
    int unsigned pct;
    n = 0;
    flagged = 1'b0;
    if (cmd == CMD_TICK) begin
      if (counting) begin
        ticks_seen = count_up(ticks_seen);
        if (ticks_seen >= cfg.window_ticks) begin
          pct = (total_cnt == 0) ? 0 : (PCT_SCALE * bad_cnt) / total_cnt;
          armed = 1'b1;
          counting = 1'b0;
          if (pct >= cfg.percent_min && bad_cnt >= cfg.bad_min && cfg.monitor_enabled) begin
            made[n] = '{KIND_DATA_EXC, bad_xyz[0], bad_xyz[1], bad_xyz[2], 1'b0};
            n++;
          end
          bad_cnt = '0;
          total_cnt = '0;
          ticks_seen = '0;
        end
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        cur[i] = data[SAMPLE_W_DEFAULT*i +: SAMPLE_W_DEFAULT];
      end
      sum_xyz = int'(cur[0]) + int'(cur[1]) + int'(cur[2]);
      bad = mag(sum_xyz) > int'(cfg.sum_limit) ||
            mag(cur[0]) > int'(cfg.axis_limit) ||
            mag(cur[1]) > int'(cfg.axis_limit) ||
            mag(cur[2]) > int'(cfg.axis_limit);

      // first bad sample is counted twice: once on capture, once in the window
      if (armed && bad) begin
        counting = 1'b1;
        armed = 1'b0;
        bad_cnt = 1;
        total_cnt = 1;
        ticks_seen = '0;
        bad_xyz = cur;
      end
      if (counting) begin
        total_cnt = count_up(total_cnt);
        if (bad) begin
          bad_cnt = count_up(bad_cnt);
        end
      end

      if (armed) begin
        shown = cur;
      end else begin
        shown = bad_xyz;
      end

      if (cur[0] == 0 && cur[1] == 0 && cur[2] == 0) begin
        if (zero_run > ZERO_RUN_LIMIT) begin
          zero_run = '0;
          made[n] = '{KIND_ALL_ZERO, shown[0], shown[1], shown[2], 1'b0};
          n++;
        end else begin
          zero_run++;
        end
      end else begin
        zero_run = '0;
      end

      for (int i = 0; i < 3; i++) begin
        if (prev_xyz[i] == cur[i]) begin
          if (same_run[i] != '1) begin
            same_run[i]++;
          end
        end else begin
          same_run[i] = '0;
        end
        if (same_run[i] >= cfg.same_limit) begin
          same_run[i] = '0;
          flagged = 1'b1;
        end
        prev_xyz[i] = cur[i];
      end
      if (flagged && stuck_sent < STUCK_REPORT_CAP) begin
        stuck_sent++;
        made[n] = '{KIND_STUCK, shown[0], shown[1], shown[2], 1'b0};
        n++;
      end
    end

    if (n > 0) begin
      made[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      reports_due.push_back(made[i]);
    end
  endtask

  function automatic void compare_field(input string name, input logic signed [16:0] want,
                                        input logic signed [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  task automatic check_report();
    report_t want;
    if (reports_due.size() == 0) begin
      $error("report_kind: expected no report, got %0d", m_axis_tuser_i);
      err_count++;
    end else begin
      want = reports_due.pop_front();
      compare_field("report_kind", want.kind, m_axis_tuser_i);
      compare_field("report_x", want.x, $signed(m_axis_tdata_i[15:0]));
      compare_field("report_y", want.y, $signed(m_axis_tdata_i[31:16]));
      compare_field("report_z", want.z, $signed(m_axis_tdata_i[47:32]));
      compare_field("last_report", want.last, m_axis_tlast_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_monitor();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        apply_write(cfg_idx_i, cfg_wdata_i);
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_reports(s_axis_tuser_i, s_axis_tdata_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_report();
      end
      pending_o <= reports_due.size();
      errors_o <= err_count;
    end
  end

endmodule

// ----- sim/tb_accel_sample_health_monitor.sv -----
module tb_accel_sample_health_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  import ashm_pkg::*;

  localparam int          DATA_W        = ((3*SAMPLE_W_DEFAULT+7)/8)*8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 300;

  typedef logic signed [SAMPLE_W_DEFAULT-1:0] axis_t;

  logic                  clk_i;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic [DATA_W-1:0]     s_tdata   = '0;
  logic                  s_tuser   = CMD_SAMPLE;
  logic                  m_tready  = 1'b0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire  [DATA_W-1:0]     m_tdata;
  wire  [1:0]            m_tuser;
  wire                   m_tlast;

  int unsigned pending;
  int unsigned errors;
  cfg_t        cur_cfg;
  int unsigned burst_left   = 0;
  logic        hold_request = 1'b0;
  logic        hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;
  int unsigned stall_pct    = 0;

  accel_sample_health_monitor uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  ashm_report_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Report sink: one long hold-off on request, otherwise stall phases of random density.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready   <= 1'b0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
      stall_left <= 0;
      stall_pct  <= 0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_left <= $urandom_range(8, 64);
        case ($urandom_range(2))
          0:       stall_pct <= 0;
          1:       stall_pct <= 35;
          default: stall_pct <= 80;
        endcase
      end else begin
        stall_left <= stall_left - 1;
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic cfg_t make_cfg(input int sum, input int axis, input int win, input int pct,
                                     input int bad_min, input int same, input logic en);
    cfg_t c;
    c.sum_limit       = SUM_LIMIT_W'(sum);
    c.axis_limit      = AXIS_LIMIT_W'(axis);
    c.window_ticks    = WINDOW_W'(win);
    c.percent_min     = PERCENT_W'(pct);
    c.bad_min         = BAD_MIN_W'(bad_min);
    c.same_limit      = SAME_LIMIT_W'(same);
    c.monitor_enabled = en;
    return c;
  endfunction

  function automatic axis_t in_range_axis();
    int bound;
    bound = int'(cur_cfg.axis_limit);
    if (int'(cur_cfg.sum_limit) / 3 < bound) begin
      bound = int'(cur_cfg.sum_limit) / 3;
    end
    return axis_t'(int'($urandom_range(2 * bound)) - bound);
  endfunction

  function automatic axis_t out_of_range_axis();
    int m;
    m = $urandom_range(32768, int'(cur_cfg.axis_limit) + 1);
    if ($urandom_range(1) == 1) begin
      m = -m;
    end
    return axis_t'(m);
  endfunction

  function automatic axis_t noise_axis();
    case ($urandom_range(5))
      0:       return axis_t'(32767);
      1:       return axis_t'(-32768);
      2:       return '0;
      3:       return axis_t'(-1);
      default: return axis_t'($urandom());
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(CFG_SUM_LIMIT, c.sum_limit);
    write_reg(CFG_AXIS_LIMIT, c.axis_limit);
    write_reg(CFG_WINDOW_TICKS, c.window_ticks);
    write_reg(CFG_PERCENT_MIN, c.percent_min);
    write_reg(CFG_BAD_MIN, c.bad_min);
    write_reg(CFG_SAME_LIMIT, c.same_limit);
    write_reg(CFG_MON_ENABLE, c.monitor_enabled);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    cur_cfg = c;
  endtask

  // Offers one transaction, in bursts separated by random gaps.
  task automatic offer_item(input logic cmd, input int x, input int y, input int z);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, ($urandom_range(4) == 0) ? 120 : 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {axis_t'(z), axis_t'(y), axis_t'(x)};
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic offer_sample(input logic want_bad);
    axis_t v [3];
    for (int i = 0; i < 3; i++) begin
      v[i] = in_range_axis();
    end
    if (want_bad) begin
      v[$urandom_range(2)] = out_of_range_axis();
    end
    offer_item(CMD_SAMPLE, v[0], v[1], v[2]);
  endtask

  // Stops offering, waits for every outstanding report, then lets silent items retire.
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_traffic(input int unsigned budget);
    int unsigned done;
    int unsigned pick;
    int unsigned len;
    int unsigned bad_pct;
    int unsigned ticks;
    axis_t       v [3];
    done = 0;
    while (done < budget) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // bad sample, then groups of samples each ending in a tick; the window may or may not close
        bad_pct = $urandom_range(100);
        ticks = (cur_cfg.window_ticks <= 8) ? cur_cfg.window_ticks : $urandom_range(1, 4);
        if ($urandom_range(7) == 0) begin
          ticks = $urandom_range(0, ticks + 1);
        end
        offer_sample(1'b1);
        done++;
        repeat (ticks) begin
          len = $urandom_range(0, 5);
          repeat (len) begin
            offer_sample($urandom_range(99) < bad_pct);
            done++;
          end
          offer_item(CMD_TICK, noise_axis(), noise_axis(), noise_axis());
          done++;
        end
      end else if (pick < 70) begin
        // held value: zero runs and stuck axes
        len = $urandom_range(8, 16);
        for (int i = 0; i < 3; i++) begin
          v[i] = ($urandom_range(1) == 1) ? axis_t'(0) : in_range_axis();
        end
        if ($urandom_range(1) == 1) begin
          for (int i = 0; i < 3; i++) begin
            v[i] = '0;
          end
        end
        repeat (len) begin
          offer_item(CMD_SAMPLE, v[0], v[1], v[2]);
          done++;
        end
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          if ($urandom_range(1) == 1) begin
            offer_item(CMD_TICK, noise_axis(), noise_axis(), noise_axis());
          end else begin
            offer_item(CMD_SAMPLE, noise_axis(), noise_axis(), noise_axis());
          end
          done++;
        end
      end
    end
  endtask

  initial begin
    cfg_t plan;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: boundaries, both item kinds, immediate window close, zero run with stuck
    load_config(make_cfg(100, 50, 0, 0, 0, 11, 1'b1));
    offer_item(CMD_TICK, 0, 0, 0);
    offer_item(CMD_SAMPLE, -1, -1, -1);
    offer_item(CMD_SAMPLE, 50, 50, 0);
    offer_item(CMD_SAMPLE, 34, 33, 34);
    offer_item(CMD_SAMPLE, 32767, -32768, 0);
    offer_item(CMD_TICK, 0, 0, 0);
    offer_item(CMD_SAMPLE, 51, 0, 0);
    offer_item(CMD_TICK, 32767, -32768, -1);
    repeat (12) offer_item(CMD_SAMPLE, 0, 0, 0);
    offer_item(CMD_SAMPLE, 32767, 32767, 32767);
    offer_item(CMD_SAMPLE, -32768, -32768, -32768);
    offer_item(CMD_TICK, -1, -1, -1);
    settle();

    hold_request <= 1'b1;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: plan = make_cfg(6144, 2048, 3, 50, 2, 20, 1'b1);
        1: plan = make_cfg(0, 0, 1, 0, 0, 1, 1'b1);
        2: plan = make_cfg(131071, 32767, 65535, 100, 65535, 255, 1'b0);
        3: plan = make_cfg(6144, 2048, 0, 30, 1, 0, 1'b1);
        default: begin
          plan = make_cfg(($urandom_range(2) == 0) ? $urandom_range(131071)
                                                   : $urandom_range(50, 8000),
                          ($urandom_range(2) == 0) ? $urandom_range(32767)
                                                   : $urandom_range(20, 3000),
                          $urandom_range(1, 8), $urandom_range(100), $urandom_range(8),
                          $urandom_range(1, 40), $urandom_range(3) != 0);
        end
      endcase
      load_config(plan);
      run_traffic((ph == 2) ? 80 : 228);
      settle();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ashm_pkg.sv
hdl/ashm_front.sv
hdl/ashm_fifo.sv
hdl/ashm_back.sv
hdl/accel_sample_health_monitor.sv
sim/ashm_report_checker.sv
sim/tb_accel_sample_health_monitor.sv
